// ----- hdl/tdpt_pkg.sv -----
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared widths, constants and types of the trial division prime tester.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    localparam int VALUE_WIDTH   = 16;
    localparam int COUNT_WIDTH   = 16;
    // A trial divisor never goes past floor(sqrt(n)) + 1.
    localparam int DIV_WIDTH     = (VALUE_WIDTH + 1) / 2 + 1;
    localparam int SQ_WIDTH      = VALUE_WIDTH + 1;
    localparam int STEP_WIDTH    = $clog2(VALUE_WIDTH);
    localparam int S_TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH = ((VALUE_WIDTH + 2 * COUNT_WIDTH + 7) / 8) * 8;
    localparam int FIRST_DIVISOR = 2;

    typedef struct packed {
        logic                   start;
        logic [VALUE_WIDTH-1:0] dividend;
        logic [DIV_WIDTH-1:0]   divisor;
    } rem_request_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } rem_status_t;

endpackage

// ----- hdl/tdpt_rem_unit.sv -----
// ----------------------------------------------------------------------------
// tdpt_rem_unit
// Bit-serial restoring remainder: one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module tdpt_rem_unit
    import tdpt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  rem_request_t req,
    output rem_status_t  stat
);

    logic [VALUE_WIDTH-1:0] shift_reg;
    logic [DIV_WIDTH-1:0]   rem_reg;
    logic [DIV_WIDTH-1:0]   div_reg;
    logic [STEP_WIDTH-1:0]  step_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic                   zero_reg;

    logic [DIV_WIDTH:0]     trial;
    logic                   fits;
    logic [DIV_WIDTH-1:0]   rem_next;

    always_comb begin
        trial = {rem_reg, shift_reg[VALUE_WIDTH-1]};
        fits  = (trial >= {1'b0, div_reg});
        if (fits) begin
            rem_next = DIV_WIDTH'(trial - {1'b0, div_reg});
        end else begin
            rem_next = trial[DIV_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (busy_reg) begin
                shift_reg <= {shift_reg[VALUE_WIDTH-2:0], 1'b0};
                rem_reg   <= rem_next;
                step_reg  <= step_reg - 1'b1;
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    zero_reg <= (rem_next == '0);
                end
            end else if (req.start) begin
                shift_reg <= req.dividend;
                div_reg   <= req.divisor;
                rem_reg   <= '0;
                step_reg  <= STEP_WIDTH'(VALUE_WIDTH - 1);
                busy_reg  <= 1'b1;
            end
        end
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.rem_zero = zero_reg;

    // A finished remainder always follows the last busy cycle.
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("remainder done without a preceding busy cycle");

endmodule

// ----- hdl/trial_division_prime_test.sv -----
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Primality test by trial division with saturating prime and tested counts.
// ----------------------------------------------------------------------------
//  Channel  Direction  tdata (low bit up)                          tuser
//  s_axis   in         candidate                                   -
//  m_axis   out        tested_value, primes_found, numbers_tested  is_prime
//
// One candidate is worked on at a time. Divisors 2, 3, ... are tried while
// d*d <= n, each through the bit-serial remainder unit; a 16-bit prime near
// 65535 needs 254 divisors. Reset clears both counts and the control state.
// A stalled result sits in the output register while the next candidate is
// already accepted.
module trial_division_prime_test
    import tdpt_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [S_TDATA_WIDTH-1:0] s_axis_tdata,   // candidate
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [M_TDATA_WIDTH-1:0] m_axis_tdata,   // tested_value, primes_found,
                                                     // numbers_tested
    output logic                     m_axis_tuser    // is_prime
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WAIT,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    logic [VALUE_WIDTH-1:0] n_reg;
    logic [DIV_WIDTH-1:0]   d_reg;
    logic [SQ_WIDTH-1:0]    sq_reg;
    logic                   prime_reg;
    logic [COUNT_WIDTH-1:0] prime_total_reg;
    logic [COUNT_WIDTH-1:0] tested_total_reg;
    logic                   m_valid_reg;
    logic [VALUE_WIDTH-1:0] out_value_reg;
    logic                   out_prime_reg;
    logic [COUNT_WIDTH-1:0] out_primes_reg;
    logic [COUNT_WIDTH-1:0] out_tested_reg;

    logic [COUNT_WIDTH-1:0] prime_total_next;
    logic [COUNT_WIDTH-1:0] tested_total_next;
    logic [SQ_WIDTH-1:0]    sq_next;
    logic                   too_small;
    logic                   past_root;
    logic                   out_free;
    logic                   in_accept;

    rem_request_t rem_req;
    rem_status_t  rem_stat;

    tdpt_rem_unit u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rem_req),
        .stat    (rem_stat)
    );

    always_comb begin
        too_small = (n_reg < VALUE_WIDTH'(FIRST_DIVISOR));
        past_root = (sq_reg > {1'b0, n_reg});
        // (d+1)^2 = d^2 + 2d + 1
        sq_next   = sq_reg + SQ_WIDTH'({d_reg, 1'b0}) + SQ_WIDTH'(1);
        out_free  = !m_valid_reg || m_axis_tready;
        in_accept = s_axis_tvalid && (state_reg == ST_IDLE);

        tested_total_next = (tested_total_reg == '1) ? tested_total_reg
                                                     : tested_total_reg + 1'b1;
        if (prime_reg && (prime_total_reg != '1)) begin
            prime_total_next = prime_total_reg + 1'b1;
        end else begin
            prime_total_next = prime_total_reg;
        end

        rem_req.start    = (state_reg == ST_CHECK) && !too_small && !past_root;
        rem_req.dividend = n_reg;
        rem_req.divisor  = d_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            prime_total_reg  <= '0;
            tested_total_reg <= '0;
        end else begin
            // In ST_FINISH the output register is reloaded below instead.
            if (m_valid_reg && m_axis_tready && (state_reg != ST_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        n_reg     <= s_axis_tdata[VALUE_WIDTH-1:0];
                        d_reg     <= DIV_WIDTH'(FIRST_DIVISOR);
                        sq_reg    <= SQ_WIDTH'(FIRST_DIVISOR * FIRST_DIVISOR);
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (too_small) begin
                        prime_reg <= 1'b0;
                        state_reg <= ST_FINISH;
                    end else if (past_root) begin
                        prime_reg <= 1'b1;
                        state_reg <= ST_FINISH;
                    end else begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (rem_stat.done) begin
                        if (rem_stat.rem_zero) begin
                            prime_reg <= 1'b0;
                            state_reg <= ST_FINISH;
                        end else begin
                            d_reg     <= d_reg + 1'b1;
                            sq_reg    <= sq_next;
                            state_reg <= ST_CHECK;
                        end
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        prime_total_reg  <= prime_total_next;
                        tested_total_reg <= tested_total_next;
                        out_value_reg    <= n_reg;
                        out_prime_reg    <= prime_reg;
                        out_primes_reg   <= prime_total_next;
                        out_tested_reg   <= tested_total_next;
                        m_valid_reg      <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = out_prime_reg;
    assign m_axis_tdata  = M_TDATA_WIDTH'({out_tested_reg, out_primes_reg, out_value_reg});

    // The remainder unit is never restarted while it still works on a divisor.
    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_req.start |-> !rem_stat.busy)
        else $error("remainder unit started while busy");

    // The running square tracks the current divisor exactly.
    a_square_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> (sq_reg == SQ_WIDTH'(d_reg) * SQ_WIDTH'(d_reg)))
        else $error("divisor square out of step");

    // Primes are a subset of tested numbers, and zero and one are never prime.
    a_counts_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_primes_reg <= out_tested_reg)
                        && !(out_prime_reg && (out_value_reg < VALUE_WIDTH'(FIRST_DIVISOR))))
        else $error("inconsistent result counts or prime flag");

endmodule
